// File: design/sus_pkg.sv
`timescale 1ns / 1ps

package sus_pkg;

  // Fixed field widths.
  localparam int KIND_W = 3;
  localparam int KEY_W = 32;
  localparam int COUNT_W = 6;

  // Default number of keys the store can hold.
  localparam int CAPACITY_DEF = 32;

  // Operation codes.
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_SEARCH = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_FIRST  = 3'd4,
    KIND_NEXT   = 3'd5
  } kind_t;

  // One operation as it arrives.
  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [KEY_W-1:0] key;
  } in_word_t;

  // One result as it leaves.
  typedef struct packed {
    logic                    ok;
    logic signed [KEY_W-1:0] value;
    logic [COUNT_W-1:0]      count;
  } out_word_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_SCAN_CMP,
    ST_INS_SHIFT,
    ST_INS_WR,
    ST_DEL_SHIFT,
    ST_DEL_WR,
    ST_WALK_DATA,
    ST_FINISH
  } state_t;

  // Where a store read takes its address from.
  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_IDX_P1,
    RD_WALK
  } rd_sel_t;

  // What a store write puts in.
  typedef enum logic {
    WR_RDATA,
    WR_KEY
  } wr_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_in;
    logic    idx_clr;
    logic    idx_inc;
    logic    idx_dec;
    logic    idx_set_held;
    logic    rank_set;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    held_inc;
    logic    held_dec;
    logic    held_clr;
    logic    walk_clr;
    logic    walk_set1;
    logic    walk_inc;
    logic    set_ok;
    logic    set_val;
    logic    res_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              idx_lt_held;
    logic              idx_gt_rank;
    logic              idx_p1_lt_held;
    logic              full;
    logic              held_nz;
    logic              walk_lt_held;
    logic              rd_lt;
    logic              rd_eq;
    logic              out_free;
  } stat_t;

endpackage

// File: design/sus_datapath.sv
`timescale 1ns / 1ps

module sus_datapath import sus_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  in_word,
  input  logic      out_stall,
  output logic      out_valid,
  output out_word_t out_word,
  input  cmd_t      cmd,
  output stat_t     stat
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // Key store, ascending by rank.
  logic signed [KEY_W-1:0] keys [CAPACITY];

  logic [KIND_W-1:0]       op;
  logic signed [KEY_W-1:0] key;
  logic signed [KEY_W-1:0] rdata;
  logic signed [KEY_W-1:0] val;
  logic                    ok;
  logic [CW-1:0]           held;
  logic [CW-1:0]           walk_pos;
  logic [CW-1:0]           idx;
  logic [CW-1:0]           rank;
  logic [CW-1:0]           idx_m1;
  logic [CW:0]             idx_p1;
  logic [CW-1:0]           rd_addr;
  logic signed [KEY_W-1:0] wr_data;

  assign idx_m1 = idx - CW'(1);
  assign idx_p1 = {1'b0, idx} + (CW + 1)'(1);

  // Read address and write data selection.
  always_comb begin
    case (cmd.rd_sel)
      RD_IDX:    rd_addr = idx;
      RD_IDX_M1: rd_addr = idx_m1;
      RD_IDX_P1: rd_addr = idx_p1[CW-1:0];
      RD_WALK:   rd_addr = walk_pos;
      default:   rd_addr = idx;
    endcase
    wr_data = (cmd.wr_sel == WR_KEY) ? key : rdata;
  end

  // Store port: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      keys[idx[AW-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= keys[rd_addr[AW-1:0]];
    end
  end

  // Operand registers and scan position.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op  <= in_word.kind;
      key <= in_word.key;
    end
    if (cmd.rank_set) begin
      rank <= idx;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_set_held) begin
      idx <= held;
    end else if (cmd.idx_inc) begin
      idx <= idx_p1[CW-1:0];
    end else if (cmd.idx_dec) begin
      idx <= idx_m1;
    end
  end

  // Fill count and walk cursor.
  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= '0;
      walk_pos <= '0;
    end else begin
      if (cmd.held_clr) begin
        held <= '0;
      end else if (cmd.held_inc) begin
        held <= held + CW'(1);
      end else if (cmd.held_dec) begin
        held <= held - CW'(1);
      end
      if (cmd.walk_clr) begin
        walk_pos <= '0;
      end else if (cmd.walk_set1) begin
        walk_pos <= CW'(1);
      end else if (cmd.walk_inc) begin
        walk_pos <= walk_pos + CW'(1);
      end
    end
  end

  // Result being built for the current operation.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ok  <= 1'b0;
      val <= '0;
    end else begin
      if (cmd.set_ok) begin
        ok <= 1'b1;
      end
      if (cmd.set_val) begin
        val <= rdata;
      end
    end
  end

  // Output register; it frees up as soon as the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_word.ok    <= ok;
      out_word.value <= val;
      out_word.count <= COUNT_W'(held);
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.kind           = op;
    stat.idx_lt_held    = idx < held;
    stat.idx_gt_rank    = idx > rank;
    stat.idx_p1_lt_held = idx_p1 < {1'b0, held};
    stat.full           = held >= CW'(CAPACITY);
    stat.held_nz        = held != '0;
    stat.walk_lt_held   = walk_pos < held;
    stat.rd_lt          = rdata < key;
    stat.rd_eq          = rdata == key;
    stat.out_free       = !out_valid || !out_stall;
  end

endmodule

// File: design/sus_ctrl.sv
`timescale 1ns / 1ps

module sus_ctrl import sus_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // An operation is only taken while nothing else is in flight.
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat.kind)
          KIND_INSERT, KIND_REMOVE, KIND_SEARCH: state_next = ST_SCAN;
          KIND_FIRST: state_next = stat.held_nz ? ST_WALK_DATA : ST_FINISH;
          KIND_NEXT:  state_next = stat.walk_lt_held ? ST_WALK_DATA : ST_FINISH;
          default:    state_next = ST_FINISH;
        endcase
      end
      ST_SCAN: begin
        if (stat.idx_lt_held) begin
          state_next = ST_SCAN_CMP;
        end else if (stat.kind == KIND_INSERT && !stat.full) begin
          state_next = ST_INS_SHIFT;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SCAN_CMP: begin
        if (stat.rd_lt) begin
          state_next = ST_SCAN;
        end else if (stat.rd_eq) begin
          state_next = (stat.kind == KIND_REMOVE) ? ST_DEL_SHIFT : ST_FINISH;
        end else if (stat.kind == KIND_INSERT && !stat.full) begin
          state_next = ST_INS_SHIFT;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_INS_SHIFT: begin
        state_next = stat.idx_gt_rank ? ST_INS_WR : ST_FINISH;
      end
      ST_INS_WR: begin
        state_next = ST_INS_SHIFT;
      end
      ST_DEL_SHIFT: begin
        state_next = stat.idx_p1_lt_held ? ST_DEL_WR : ST_FINISH;
      end
      ST_DEL_WR: begin
        state_next = ST_DEL_SHIFT;
      end
      ST_WALK_DATA: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cmd.idx_clr = 1'b1;
        end
      end
      ST_DISPATCH: begin
        case (stat.kind)
          KIND_CLEAR: begin
            cmd.held_clr = 1'b1;
            cmd.walk_clr = 1'b1;
            cmd.set_ok   = 1'b1;
          end
          KIND_FIRST: begin
            if (stat.held_nz) begin
              cmd.rd_en     = 1'b1;
              cmd.rd_sel    = RD_IDX;
              cmd.walk_set1 = 1'b1;
            end
          end
          KIND_NEXT: begin
            if (stat.walk_lt_held) begin
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = RD_WALK;
              cmd.walk_inc = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SCAN: begin
        if (stat.idx_lt_held) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
        end else if (stat.kind == KIND_INSERT && !stat.full) begin
          // Key goes after every held key.
          cmd.rank_set     = 1'b1;
          cmd.idx_set_held = 1'b1;
        end
      end
      ST_SCAN_CMP: begin
        if (stat.rd_lt) begin
          cmd.idx_inc = 1'b1;
        end else if (stat.rd_eq) begin
          if (stat.kind == KIND_SEARCH) begin
            cmd.set_ok = 1'b1;
          end
        end else if (stat.kind == KIND_INSERT && !stat.full) begin
          cmd.rank_set     = 1'b1;
          cmd.idx_set_held = 1'b1;
        end
      end
      ST_INS_SHIFT: begin
        if (stat.idx_gt_rank) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_M1;
        end else begin
          // Gap is open at the rank: drop the new key in.
          cmd.wr_en    = 1'b1;
          cmd.wr_sel   = WR_KEY;
          cmd.held_inc = 1'b1;
          cmd.set_ok   = 1'b1;
        end
      end
      ST_INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_RDATA;
        cmd.idx_dec = 1'b1;
      end
      ST_DEL_SHIFT: begin
        if (stat.idx_p1_lt_held) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_P1;
        end else begin
          cmd.held_dec = 1'b1;
          cmd.set_ok   = 1'b1;
        end
      end
      ST_DEL_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_RDATA;
        cmd.idx_inc = 1'b1;
      end
      ST_WALK_DATA: begin
        cmd.set_val = 1'b1;
        cmd.set_ok  = 1'b1;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/sorted_unique_key_set.sv
`timescale 1ns / 1ps
// Channel | Dir | Handshake          | Word
// in      | in  | in_valid, in_stall  | in_word  (kind, key)
// out     | out | out_valid, out_stall| out_word (ok, value, count)
//
// Search, insert and remove scan up from rank zero to the first key not below the operand;
// insert then shifts the keys from that rank up and remove shifts the keys above it down,
// on the single read and single write port of the store. Reset empties the store
// at once (fill count and cursor to zero). A new word is taken while the previous
// result still sits stalled; the controller holds in its final state until it frees up.

module sorted_unique_key_set import sus_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  cmd_t  cmd;
  stat_t stat;

  // Operation sequencer.
  sus_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Key store, counters and result register.
  sus_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// File: tb/tb_sorted_unique_key_set.sv
`timescale 1ns / 1ps

module tb_sorted_unique_key_set;
  import sus_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam int TOTAL_ITEMS = 1950;
  localparam int CYCLE_LIMIT = 1000000;
  // One of the longest operations is an insert at rank zero into a nearly full store.
  localparam int SETTLE_CYCLES = 200;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

  // One line of the directed plan; a run of reps words steps the key by one.
  typedef struct {
    logic [KIND_W-1:0]       kind;
    logic signed [KEY_W-1:0] key;
    int                      reps;
    bit                      known;
    out_word_t               res;
  } plan_row_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // Shadow copy of the key store.
  logic signed [KEY_W-1:0] model_keys [CAPACITY];
  int model_held = 0;
  int model_walk = 0;

  out_word_t pending_results [$];
  plan_row_t plan [$];

  int n_sent = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_full_refused = 0;
  int peak_held = 0;
  int burst_left = 0;
  int cycle_count = 0;
  int stall_mode = 0;
  int stall_mode_left = 0;

  sorted_unique_key_set #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Apply one operation to the shadow store and return the result it gives.
  function automatic out_word_t apply_op(in_word_t w);
    out_word_t res;
    int rank;
    int i;
    bit hit;
    res = '0;
    rank = 0;
    while (rank < model_held && model_keys[rank] < w.key) rank++;
    hit = (rank < model_held) && (model_keys[rank] == w.key);
    case (w.kind)
      KIND_INSERT: begin
        if (!hit && model_held < CAPACITY) begin
          for (i = model_held; i > rank; i--) model_keys[i] = model_keys[i-1];
          model_keys[rank] = w.key;
          model_held++;
          res.ok = 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (hit) begin
          for (i = rank; i + 1 < model_held; i++) model_keys[i] = model_keys[i+1];
          model_held--;
          res.ok = 1'b1;
        end
      end
      KIND_SEARCH: begin
        res.ok = hit;
      end
      KIND_CLEAR: begin
        model_held = 0;
        model_walk = 0;
        res.ok = 1'b1;
      end
      KIND_FIRST: begin
        if (model_held > 0) begin
          res.value = model_keys[0];
          model_walk = 1;
          res.ok = 1'b1;
        end
      end
      KIND_NEXT: begin
        if (model_walk < model_held) begin
          res.value = model_keys[model_walk];
          model_walk++;
          res.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.count = COUNT_W'(model_held);
    return res;
  endfunction

  // Keys lean toward a small window and toward keys already held, so that
  // duplicates, hits and misses all come up often.
  function automatic logic signed [KEY_W-1:0] pick_key(int hit_pct);
    logic signed [KEY_W-1:0] k;
    if (model_held > 0 && $urandom_range(0, 99) < hit_pct) begin
      k = model_keys[$urandom_range(0, model_held - 1)];
    end else begin
      case ($urandom_range(0, 5))
        0: k = $urandom();
        1: begin
          case ($urandom_range(0, 3))
            0: k = KEY_MIN;
            1: k = KEY_MAX;
            2: k = '0;
            default: k = '1;
          endcase
        end
        default: k = $urandom_range(0, 48) - 24;
      endcase
    end
    return k;
  endfunction

  function automatic plan_row_t step_row(logic [KIND_W-1:0] kind,
                                         logic signed [KEY_W-1:0] key, int reps);
    plan_row_t row;
    row.kind = kind;
    row.key = key;
    row.reps = reps;
    row.known = 1'b0;
    row.res = '0;
    return row;
  endfunction

  function automatic plan_row_t known_row(logic [KIND_W-1:0] kind,
                                          logic signed [KEY_W-1:0] key, bit ok,
                                          logic signed [KEY_W-1:0] value, int count);
    plan_row_t row;
    row = step_row(kind, key, 1);
    row.known = 1'b1;
    row.res.ok = ok;
    row.res.value = value;
    row.res.count = COUNT_W'(count);
    return row;
  endfunction

  task automatic report_mismatch(input string msg);
    if (n_errors < 25) $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  // Hand one word to the block. The sender runs in bursts with idle gaps between.
  task automatic send_op(input logic [KIND_W-1:0] kind, input logic signed [KEY_W-1:0] key,
                         input bit known, input out_word_t known_res);
    in_word_t w;
    out_word_t res;
    int gap;
    w.kind = kind;
    w.key = key;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = apply_op(w);
    pending_results.push_back(known ? known_res : res);
    n_sent++;
    if (kind == KIND_INSERT && !res.ok && model_held == CAPACITY) n_full_refused++;
    if (model_held > peak_held) peak_held = model_held;
  endtask

  task automatic send(input logic [KIND_W-1:0] kind, input logic signed [KEY_W-1:0] key);
    send_op(kind, key, 1'b0, '0);
  endtask

  // Receiver stall pattern: free-running, light or heavy stretches.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_mode_left = $urandom_range(20, 200);
      end
      stall_mode_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // Compare each accepted result with the oldest outstanding expectation.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding: ok %0b value %0d count %0d",
                                  out_word.ok, out_word.value, out_word.count));
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_word.ok !== want.ok)
          report_mismatch($sformatf("result %0d ok %0b, expected %0b",
                                    n_checked, out_word.ok, want.ok));
        if (out_word.value !== want.value)
          report_mismatch($sformatf("result %0d value %0d, expected %0d",
                                    n_checked, out_word.value, want.value));
        if (out_word.count !== want.count)
          report_mismatch($sformatf("result %0d count %0d, expected %0d",
                                    n_checked, out_word.count, want.count));
      end
    end
  end

  // Give up if the run hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [KIND_W-1:0] kind_pick;
    int n;
    int tries;

    // Empty store, both extremes, duplicates, spare kinds, a full store,
    // walking off the end, and a walk that continues across an insert and a remove.
    plan.push_back(known_row(KIND_SEARCH, '0, 1'b0, '0, 0));
    plan.push_back(known_row(KIND_FIRST, '0, 1'b0, '0, 0));
    plan.push_back(known_row(KIND_NEXT, '1, 1'b0, '0, 0));
    plan.push_back(known_row(KIND_REMOVE, 5, 1'b0, '0, 0));
    plan.push_back(known_row(KIND_INSERT, KEY_MAX, 1'b1, '0, 1));
    plan.push_back(known_row(KIND_INSERT, KEY_MIN, 1'b1, '0, 2));
    plan.push_back(known_row(KIND_INSERT, KEY_MAX, 1'b0, '0, 2));
    plan.push_back(known_row(KIND_INSERT, '0, 1'b1, '0, 3));
    plan.push_back(known_row(KIND_INSERT, '1, 1'b1, '0, 4));
    plan.push_back(known_row(KIND_FIRST, KEY_MAX, 1'b1, KEY_MIN, 4));
    plan.push_back(step_row(KIND_NEXT, '0, 4));
    plan.push_back(known_row(KIND_SEARCH, KEY_MIN, 1'b1, '0, 4));
    plan.push_back(known_row(KIND_REMOVE, 7, 1'b0, '0, 4));
    plan.push_back(known_row(KIND_REMOVE, KEY_MAX, 1'b1, '0, 3));
    plan.push_back(known_row(KIND_SPARE6, KEY_MIN, 1'b0, '0, 3));
    plan.push_back(known_row(KIND_SPARE7, '1, 1'b0, '0, 3));
    plan.push_back(known_row(KIND_CLEAR, KEY_MAX, 1'b1, '0, 0));
    plan.push_back(known_row(KIND_NEXT, '0, 1'b0, '0, 0));
    plan.push_back(step_row(KIND_INSERT, 1000, CAPACITY));
    plan.push_back(known_row(KIND_INSERT, -7, 1'b0, '0, CAPACITY));
    plan.push_back(known_row(KIND_INSERT, 1005, 1'b0, '0, CAPACITY));
    plan.push_back(known_row(KIND_FIRST, '0, 1'b1, 1000, CAPACITY));
    plan.push_back(step_row(KIND_NEXT, '0, CAPACITY + 1));
    plan.push_back(step_row(KIND_REMOVE, 1000, CAPACITY));
    plan.push_back(step_row(KIND_INSERT, 10, 3));
    plan.push_back(step_row(KIND_FIRST, '0, 1));
    plan.push_back(step_row(KIND_INSERT, 5, 1));
    plan.push_back(step_row(KIND_NEXT, '0, 1));
    plan.push_back(step_row(KIND_REMOVE, 5, 1));
    plan.push_back(step_row(KIND_NEXT, '0, 1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[p]) begin
      for (int i = 0; i < plan[p].reps; i++) begin
        send_op(plan[p].kind, plan[p].key + i, plan[p].known, plan[p].res);
      end
    end

    // Random part: mostly fills, walks and drains with random content, plus noise.
    while (n_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          tries = 0;
          while (model_held < CAPACITY && tries < 3 * CAPACITY) begin
            send(KIND_INSERT, pick_key(10));
            tries++;
          end
          send(KIND_INSERT, pick_key(30));
        end
        2, 3: begin
          send(KIND_FIRST, $urandom());
          n = $urandom_range(0, model_held + 2);
          repeat (n) begin
            if ($urandom_range(0, 5) == 0)
              send(($urandom_range(0, 1) == 1) ? KIND_INSERT : KIND_REMOVE, pick_key(50));
            else
              send(KIND_NEXT, $urandom());
          end
        end
        4: begin
          n = $urandom_range(1, model_held + 2);
          repeat (n) send(KIND_REMOVE, pick_key(80));
        end
        5: begin
          send(KIND_CLEAR, $urandom());
        end
        default: begin
          repeat ($urandom_range(4, 16)) begin
            if ($urandom_range(0, 24) == 0)
              kind_pick = ($urandom_range(0, 1) == 1) ? KIND_SPARE6 : KIND_SPARE7;
            else
              kind_pick = KIND_W'($urandom_range(KIND_INSERT, KIND_NEXT));
            send(kind_pick, pick_key(40));
          end
        end
      endcase
    end

    @(posedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d operations and checked %0d results; mismatches: %0d.",
             n_sent, n_checked, n_errors);
    $display("Store peaked at %0d keys; %0d inserts were refused on a full store.",
             peak_held, n_full_refused);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
